/* rtl/assert_macros.svh */
// Assertion macros shared by the vertex dedup RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define VDH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vdh assertion failed");
// Checks that a condition implies another on the same edge.
`define VDH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdh implication failed");
`else
`define VDH_ASSERT(lbl, clk, rst_n, prop)
`define VDH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/vdh_pkg.sv */
// Shared types, constants and functions of the vertex dedup hash table.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package vdh_pkg;

    localparam int FIELD_W     = 32;
    localparam int NUM_FIELDS  = 8;
    localparam int INDEX_W     = 12;
    localparam int NEXT_W      = INDEX_W + 1;
    localparam int DEF_TABLE_SLOTS = 4096;
    localparam int DEF_MAX_PROBES  = 16;

    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] t_vertex;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } t_state;

    // Kind of result that the datapath registers.
    typedef enum logic [1:0] {
        RES_CLEAR,
        RES_HIT,
        RES_NEW,
        RES_OVF
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_item;
        logic     clear_init;
        logic     clear_step;
        logic     advance;
        logic     insert;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic occupied;
        logic match;
        logic full;
        logic last_probe;
    } t_dp_sts;

    // IEEE single equality on bit patterns: NaN never matches, +0 equals -0.
    function automatic logic feq(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[FIELD_W-2:0] > 31'h7F80_0000);
        b_nan = (b[FIELD_W-2:0] > 31'h7F80_0000);
        return !a_nan && !b_nan && ((a == b) || ((a[FIELD_W-2:0] | b[FIELD_W-2:0]) == '0));
    endfunction

endpackage

/* rtl/vdh_channels.sv */
// Valid/ready channel interfaces for vertex beats in and result beats out.
// Depends on vdh_pkg for field and index widths.
interface vdh_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [vdh_pkg::FIELD_W-1:0]  pos_x;
    logic [vdh_pkg::FIELD_W-1:0]  pos_y;
    logic [vdh_pkg::FIELD_W-1:0]  pos_z;
    logic [vdh_pkg::FIELD_W-1:0]  norm_x;
    logic [vdh_pkg::FIELD_W-1:0]  norm_y;
    logic [vdh_pkg::FIELD_W-1:0]  norm_z;
    logic [vdh_pkg::FIELD_W-1:0]  tex_s;
    logic [vdh_pkg::FIELD_W-1:0]  tex_t;

    modport source (output valid, action, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_s, tex_t, input ready);
    modport sink (input valid, action, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_s, tex_t, output ready);
endinterface

interface vdh_out_if;
    logic                         valid;
    logic                         ready;
    logic [vdh_pkg::INDEX_W-1:0]  vertex_index;
    logic                         is_new;
    logic                         overflow;

    modport source (output valid, vertex_index, is_new, overflow, input ready);
    modport sink (input valid, vertex_index, is_new, overflow, output ready);
endinterface

/* rtl/vdh_datapath.sv */
// Datapath: slot memory, item and probe registers, match logic, result register.
// Depends on vdh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vdh_datapath #(
    parameter int TABLE_SLOTS = vdh_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_PROBES  = vdh_pkg::DEF_MAX_PROBES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vdh_pkg::t_vertex             i_vertex,
    input  vdh_pkg::t_dp_cmd             i_cmd,
    output vdh_pkg::t_dp_sts             o_sts,
    output logic [vdh_pkg::INDEX_W-1:0]  o_vertex_index,
    output logic                         o_is_new,
    output logic                         o_overflow
);
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PROBE_W = $clog2(MAX_PROBES + 1);

    typedef struct packed {
        logic                         occupied;
        logic [vdh_pkg::INDEX_W-1:0]  index;
        vdh_pkg::t_vertex             vertex;
    } t_slot_entry;

    t_slot_entry                 mem [TABLE_SLOTS];
    t_slot_entry                 r_rd;
    vdh_pkg::t_vertex            r_vertex;
    logic [SLOT_W-1:0]           r_slot;
    logic [SLOT_W-1:0]           r_clr_ctr;
    logic [PROBE_W-1:0]          r_probe;
    logic [vdh_pkg::NEXT_W-1:0]  r_next_free;
    logic [vdh_pkg::INDEX_W-1:0] r_res_index;
    logic                        r_res_new;
    logic                        r_res_ovf;
    logic [SLOT_W-1:0]           key;
    logic                        match;
    logic                        we;
    logic [SLOT_W-1:0]           wa;
    t_slot_entry                 wd;

    // Home slot: XOR fold of the fields, low bits kept. A negative zero only
    // differs from positive zero in the sign bit, so the low bits need no fixup.
    always_comb begin
        key = '0;
        for (int f = 0; f < vdh_pkg::NUM_FIELDS; f++) begin
            key = key ^ i_vertex[f][SLOT_W-1:0];
        end
    end

    // Field-wise IEEE compare of the slot just read against the held vertex.
    always_comb begin
        match = 1'b1;
        for (int f = 0; f < vdh_pkg::NUM_FIELDS; f++) begin
            match = match & vdh_pkg::feq(r_rd.vertex[f], r_vertex[f]);
        end
    end

    // Write port: the clear sweep writes free entries, an insert a full one.
    always_comb begin
        we = i_cmd.clear_step || i_cmd.insert;
        wa = i_cmd.clear_step ? r_clr_ctr : r_slot;
        wd.occupied = i_cmd.insert;
        wd.index    = r_next_free[vdh_pkg::INDEX_W-1:0];
        wd.vertex   = r_vertex;
    end

    // Slot memory with one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[r_slot];
    end

    // Item and probe address registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_vertex <= i_vertex;
            r_slot   <= key;
        end else if (i_cmd.advance) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
    end

    // Control counters: probe count, clear sweep and next dense index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe     <= '0;
            r_clr_ctr   <= '0;
            r_next_free <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_probe <= '0;
            end else if (i_cmd.advance) begin
                r_probe <= r_probe + PROBE_W'(1);
            end
            if (i_cmd.clear_init) begin
                r_clr_ctr   <= '0;
                r_next_free <= '0;
            end else begin
                if (i_cmd.clear_step) begin
                    r_clr_ctr <= r_clr_ctr + SLOT_W'(1);
                end
                if (i_cmd.insert) begin
                    r_next_free <= r_next_free + vdh_pkg::NEXT_W'(1);
                end
            end
        end
    end

    // Result register held until the result beat is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                vdh_pkg::RES_CLEAR: begin
                    r_res_index <= '0;
                    r_res_new   <= 1'b0;
                    r_res_ovf   <= 1'b0;
                end
                vdh_pkg::RES_HIT: begin
                    r_res_index <= r_rd.index;
                    r_res_new   <= 1'b0;
                    r_res_ovf   <= 1'b0;
                end
                vdh_pkg::RES_NEW: begin
                    r_res_index <= r_next_free[vdh_pkg::INDEX_W-1:0];
                    r_res_new   <= 1'b1;
                    r_res_ovf   <= 1'b0;
                end
                vdh_pkg::RES_OVF: begin
                    r_res_index <= '0;
                    r_res_new   <= 1'b0;
                    r_res_ovf   <= 1'b1;
                end
                default: begin
                    r_res_index <= '0;
                    r_res_new   <= 1'b0;
                    r_res_ovf   <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.clear_done = (r_clr_ctr == SLOT_W'(TABLE_SLOTS - 1));
    assign o_sts.occupied   = r_rd.occupied;
    assign o_sts.match      = match;
    assign o_sts.full       = r_next_free[vdh_pkg::INDEX_W];
    assign o_sts.last_probe = (r_probe == PROBE_W'(MAX_PROBES - 1));

    assign o_vertex_index = r_res_index;
    assign o_is_new       = r_res_new;
    assign o_overflow     = r_res_ovf;

    // An insert hands out exactly one new index.
    `VDH_ASSERT(a_insert_counts, i_clk, i_rst_n, i_cmd.insert |=> (r_next_free == $past(r_next_free) + vdh_pkg::NEXT_W'(1)))
    // Inserting into a full store would reuse an index.
    `VDH_ASSERT_IMPL(a_insert_not_full, i_clk, i_rst_n, i_cmd.insert, !r_next_free[vdh_pkg::INDEX_W])
endmodule

/* rtl/vdh_controller.sv */
// Controller state machine: clear sweep, probe sequencing and beat handshakes.
// Depends on vdh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vdh_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  vdh_pkg::t_dp_sts  i_sts,
    output vdh_pkg::t_dp_cmd  o_cmd
);
    vdh_pkg::t_state r_state;
    vdh_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdh_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.res_sel = vdh_pkg::RES_CLEAR;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        unique case (r_state)
            vdh_pkg::ST_INIT: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = vdh_pkg::ST_IDLE;
                end
            end
            vdh_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_action) begin
                        o_cmd.clear_init = 1'b1;
                        n_state          = vdh_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_state         = vdh_pkg::ST_READ;
                    end
                end
            end
            vdh_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = vdh_pkg::RES_CLEAR;
                    n_state        = vdh_pkg::ST_RESP;
                end
            end
            vdh_pkg::ST_READ: begin
                n_state = vdh_pkg::ST_CHECK;
            end
            vdh_pkg::ST_CHECK: begin
                priority if (!i_sts.occupied && i_sts.full) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = vdh_pkg::RES_OVF;
                    n_state        = vdh_pkg::ST_RESP;
                end else if (!i_sts.occupied) begin
                    o_cmd.insert   = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = vdh_pkg::RES_NEW;
                    n_state        = vdh_pkg::ST_RESP;
                end else if (i_sts.match) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = vdh_pkg::RES_HIT;
                    n_state        = vdh_pkg::ST_RESP;
                end else if (i_sts.last_probe) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = vdh_pkg::RES_OVF;
                    n_state        = vdh_pkg::ST_RESP;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = vdh_pkg::ST_READ;
                end
            end
            vdh_pkg::ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = vdh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vdh_pkg::ST_INIT;
            end
        endcase
    end

    // A new beat is never taken while a result beat waits.
    `VDH_ASSERT_IMPL(a_one_in_flight, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    // A stalled result stays offered.
    `VDH_ASSERT(a_resp_holds, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid)
endmodule

/* rtl/vertex_dedup_hash_table_top.sv */
// Vertex dedup hash table: accepts a clear or a vertex beat, returns one result beat.
// After reset, and for each clear beat, a sweep frees every slot, one slot per cycle,
// and no beat is accepted during the sweep (TABLE_SLOTS is 4096 by default). A vertex
// beat probes from 1 to MAX_PROBES slots in the states READ and CHECK: each probe is
// one registered read of the slot memory, whose data is checked in the following cycle.
// The result beat is offered in RESP, and the next beat is accepted back in IDLE once
// the result is taken. TABLE_SLOTS must be a power of two; the home slot is the low bits
// of the XOR fold of the eight fields. One beat is in flight at a time. Depends on
// vdh_pkg, vdh_channels, vdh_controller and vdh_datapath.
module vertex_dedup_hash_table_top #(
    parameter int TABLE_SLOTS = vdh_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_PROBES  = vdh_pkg::DEF_MAX_PROBES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vdh_in_if.sink    i_in,
    vdh_out_if.source o_out
);
    vdh_pkg::t_dp_cmd cmd;
    vdh_pkg::t_dp_sts sts;
    vdh_pkg::t_vertex vertex;

    // Field order matches the memory packing, low word first.
    assign vertex[0] = i_in.pos_x;
    assign vertex[1] = i_in.pos_y;
    assign vertex[2] = i_in.pos_z;
    assign vertex[3] = i_in.norm_x;
    assign vertex[4] = i_in.norm_y;
    assign vertex[5] = i_in.norm_z;
    assign vertex[6] = i_in.tex_s;
    assign vertex[7] = i_in.tex_t;

    vdh_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vdh_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_PROBES  (MAX_PROBES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex       (vertex),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_vertex_index (o_out.vertex_index),
        .o_is_new       (o_out.is_new),
        .o_overflow     (o_out.overflow)
    );
endmodule

/* tb/vertex_dedup_hash_table_top_test.sv */
// Self-checking testbench for the vertex dedup hash table: directed corner cases,
// a full-store fill, then random vertex and clear beats against an in-bench predictor.
// Depends on vdh_pkg, vdh_channels and vertex_dedup_hash_table_top.
module vertex_dedup_hash_table_top_test;
    localparam int FIELD_W     = vdh_pkg::FIELD_W;
    localparam int NUM_FIELDS  = vdh_pkg::NUM_FIELDS;
    localparam int INDEX_W     = vdh_pkg::INDEX_W;
    localparam int SLOTS       = vdh_pkg::DEF_TABLE_SLOTS;
    localparam int PROBES      = vdh_pkg::DEF_MAX_PROBES;
    localparam int INDEX_SPAN  = 1 << INDEX_W;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam bit ACT_INSERT  = 1'b0;
    localparam bit ACT_CLEAR   = 1'b1;

    typedef vdh_pkg::t_vertex t_vertex;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_new;
        logic               overflow;
    } t_lookup_res;

    // Mirror of the slot store that works out the result of every accepted beat.
    class dedup_scoreboard;
        t_vertex            slot_vtx [SLOTS];
        logic [INDEX_W-1:0] slot_idx [SLOTS];
        bit                 slot_used[SLOTS];
        int unsigned        next_idx;
        t_lookup_res        pending_q[$];
        int                 errors;

        function new();
            foreach (slot_used[s]) slot_used[s] = 1'b0;
            next_idx = 0;
            errors = 0;
        endfunction

        static function bit is_nan(logic [FIELD_W-1:0] a);
            return a[FIELD_W-2:0] > 31'h7F80_0000;
        endfunction

        // IEEE equality over all eight fields.
        static function bit same_vertex(t_vertex a, t_vertex b);
            for (int k = 0; k < NUM_FIELDS; k++) begin
                if (is_nan(a[k]) || is_nan(b[k])) return 1'b0;
                if (a[k] != b[k] && (a[k][FIELD_W-2:0] | b[k][FIELD_W-2:0]) != '0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        static function int home_slot(t_vertex v);
            logic [FIELD_W-1:0] fold;
            fold = '0;
            for (int k = 0; k < NUM_FIELDS; k++)
                fold ^= (v[k] == 32'h8000_0000) ? 32'h0 : v[k];
            return int'(fold % SLOTS);
        endfunction

        // Predicts the result of one accepted beat and updates the mirror.
        function void note(bit action, t_vertex v);
            t_lookup_res r;
            int s;
            r = '0;
            if (action == ACT_CLEAR) begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
                next_idx = 0;
                pending_q.push_back(r);
                return;
            end
            r.overflow = 1'b1;
            for (int p = 0; p < PROBES; p++) begin
                s = (home_slot(v) + p) % SLOTS;
                if (!slot_used[s]) begin
                    if (next_idx < INDEX_SPAN) begin
                        slot_vtx[s] = v;
                        slot_idx[s] = next_idx[INDEX_W-1:0];
                        slot_used[s] = 1'b1;
                        r.vertex_index = next_idx[INDEX_W-1:0];
                        r.is_new = 1'b1;
                        r.overflow = 1'b0;
                        next_idx++;
                    end
                    break;
                end
                if (same_vertex(slot_vtx[s], v)) begin
                    r.vertex_index = slot_idx[s];
                    r.overflow = 1'b0;
                    break;
                end
            end
            pending_q.push_back(r);
        endfunction

        // Compares one result beat with the oldest prediction.
        function void check(t_lookup_res got);
            t_lookup_res exp;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: index %0d new %0b ovf %0b",
                         $time, got.vertex_index, got.is_new, got.overflow);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.vertex_index !== exp.vertex_index) begin
                $display("%0t: vertex_index expected %0d actual %0d",
                         $time, exp.vertex_index, got.vertex_index);
                errors++;
            end
            if (got.is_new !== exp.is_new) begin
                $display("%0t: is_new expected %0b actual %0b", $time, exp.is_new, got.is_new);
                errors++;
            end
            if (got.overflow !== exp.overflow) begin
                $display("%0t: overflow expected %0b actual %0b",
                         $time, exp.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    vdh_in_if  in_ch();
    vdh_out_if out_ch();

    vertex_dedup_hash_table_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    dedup_scoreboard dedup_sb = new();
    int unsigned in_beats  = 0;
    int unsigned out_beats = 0;
    int unsigned cycles    = 0;
    bit          no_gaps   = 1'b0;
    bit          sending_done = 1'b0;
    t_vertex     recent_pool[$];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watch both channels at the rising edge; count beats for the drivers.
    always @(posedge i_clk) begin
        t_vertex v;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("vertex_dedup_hash_table_top verification failed");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            dedup_sb.check('{out_ch.vertex_index, out_ch.is_new, out_ch.overflow});
            out_beats++;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            v = {in_ch.tex_t, in_ch.tex_s, in_ch.norm_z, in_ch.norm_y,
                 in_ch.norm_x, in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
            dedup_sb.note(in_ch.action, v);
            in_beats++;
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : ((($urandom & 3) == 0) ? 0 : $urandom_range(0, 18));
    endfunction

    // Result side: stall a random number of cycles before each beat.
    initial begin
        int stall;
        int unsigned seen;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            seen = out_beats;
            while (out_beats == seen) @(negedge i_clk);
        end
    end

    // Presents one beat after a random gap and holds it until accepted.
    task automatic send_beat(bit action, t_vertex v);
        int gap;
        int unsigned seen;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= action;
        {in_ch.tex_t, in_ch.tex_s, in_ch.norm_z, in_ch.norm_y,
         in_ch.norm_x, in_ch.pos_z, in_ch.pos_y, in_ch.pos_x} <= v;
        seen = in_beats;
        do @(negedge i_clk); while (in_beats == seen);
        if (action == ACT_INSERT) begin
            recent_pool.push_back(v);
            if (recent_pool.size() > 64) void'(recent_pool.pop_front());
        end
    endtask

    task automatic send_vertex(t_vertex v);
        send_beat(ACT_INSERT, v);
    endtask

    task automatic send_clear();
        send_beat(ACT_CLEAR, t_vertex'($urandom));
        recent_pool.delete();
    endtask

    function automatic logic [FIELD_W-1:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h7FC0_0000;
            5: return 32'hFFFF_FFFF;
            6: return 32'h3F80_0000;
            default: return $urandom;
        endcase
    endfunction

    // A vertex with only pos_x and tex_t set whose home slot is the given one.
    function automatic t_vertex slot_vertex(int slot, int tag);
        t_vertex v;
        v = '0;
        v[0] = (tag + 1) << 12;
        v[7] = slot;
        return v;
    endfunction

    initial begin
        t_vertex a, v;
        int hot_slot[4];
        int pick;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_INSERT;
        {in_ch.tex_t, in_ch.tex_s, in_ch.norm_z, in_ch.norm_y,
         in_ch.norm_x, in_ch.pos_z, in_ch.pos_y, in_ch.pos_x} = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: hit, signed zero, NaN, infinity, all-ones and all-zero vertices.
        a = {32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'h0, 32'h0,
             32'h4000_0000, 32'h0000_0000, 32'h3F00_0000};
        send_vertex(a);
        send_vertex(a);
        v = a;
        v[1] = 32'h8000_0000;
        v[3] = 32'h8000_0000;
        send_vertex(v);
        v = a;
        v[5] = 32'h7FC0_0001;
        send_vertex(v);
        send_vertex(v);
        v = a;
        v[2] = 32'hFF80_0000;
        send_vertex(v);
        send_vertex(v);
        send_vertex('1);
        send_vertex('0);
        send_vertex({NUM_FIELDS{32'h8000_0000}});

        // Directed: one home slot near the top, probing wraps and then runs out.
        for (int j = 0; j <= PROBES; j++) send_vertex(slot_vertex(SLOTS - 6, j));
        send_vertex(slot_vertex(SLOTS - 6, 3));
        send_clear();
        send_vertex(a);
        send_clear();

        // Fill every index back to back, then overflow and a hit on the full store.
        no_gaps = 1'b1;
        for (int i = 0; i < INDEX_SPAN; i++) begin
            v = '0;
            v[0] = i;
            send_vertex(v);
        end
        v = '0;
        v[0] = 32'h0001_2345;
        send_vertex(v);
        v = '0;
        v[0] = 7;
        send_vertex(v);
        no_gaps = 1'b0;
        send_clear();

        // Random part: mostly reuse and collisions, with fresh and broken vertices.
        foreach (hot_slot[h]) hot_slot[h] = $urandom_range(0, SLOTS - 1);
        for (int n = 0; n < 1600; n++) begin
            if (n % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
                send_clear();
                continue;
            end
            if (pick < 45 && recent_pool.size() > 0) begin
                v = recent_pool[$urandom_range(0, recent_pool.size() - 1)];
                for (int k = 0; k < NUM_FIELDS; k++)
                    if (v[k][FIELD_W-2:0] == '0 && $urandom_range(0, 1))
                        v[k][FIELD_W-1] = ~v[k][FIELD_W-1];
            end else if (pick < 65) begin
                v = slot_vertex(hot_slot[$urandom_range(0, 3)], $urandom_range(0, 23));
            end else begin
                for (int k = 0; k < NUM_FIELDS; k++) v[k] = pick_field();
                if (pick < 75) v[$urandom_range(0, 7)] = {1'($urandom_range(0, 1)), 8'hFF,
                                                          23'($urandom_range(1, 32'h7F_FFFF))};
            end
            send_vertex(v);
        end
        in_ch.valid <= 1'b0;

        // Drain what is left, then allow a few more cycles for a stray beat.
        while (dedup_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (dedup_sb.errors == 0)
            $display("vertex_dedup_hash_table_top verification clean");
        else
            $display("vertex_dedup_hash_table_top verification failed");
        $finish;
    end
endmodule
